@@ design/jdpq_pkg.sv @@
// ----------------------------------------------------------------------------
// jdpq_pkg: shared types for the job deadline priority queue
// Item layouts, operation and status codes, and the per-slot entry record.
// ----------------------------------------------------------------------------
package jdpq_pkg;

    localparam int ID_BITS       = 16;
    localparam int TIME_BITS     = 48;
    localparam int PRIORITY_BITS = 8;
    localparam int COUNT_BITS    = 7;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic [ID_BITS-1:0]       job_id;
        logic [TIME_BITS-1:0]     run_at;
        logic [PRIORITY_BITS-1:0] priority_req;
    } job_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [ID_BITS-1:0]       out_job_id;
        logic [TIME_BITS-1:0]     out_run_at;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic [COUNT_BITS-1:0]    entry_count;
    } result_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0]       job_id;
        logic [TIME_BITS-1:0]     run_at;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    // Operation strobes broadcast to every cell for one accepted item
    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
    } cell_ctrl_t;

endpackage

@@ design/jdpq_cell.sv @@
// ----------------------------------------------------------------------------
// jdpq_cell: one slot of the sorted queue
// Holds one job, compares it to the broadcast key and takes its next value
// from itself, the new job, or a neighbor.
// ----------------------------------------------------------------------------
module jdpq_cell (
    input  logic                 clk,
    input  jdpq_pkg::cell_ctrl_t ctrl,
    input  jdpq_pkg::entry_t     new_entry,
    input  jdpq_pkg::entry_t     prev_entry,
    input  jdpq_pkg::entry_t     next_entry,
    input  logic                 occupied,
    input  logic                 prev_after,
    input  logic                 shift_up,
    output jdpq_pkg::entry_t     entry,
    output logic                 after,
    output logic                 match
);

    jdpq_pkg::entry_t entry_reg;
    jdpq_pkg::entry_t entry_next;

    // Held job is served after the new one: later run time, or same run time
    // and larger priority value. Equal keys stay ahead of the newcomer.
    assign after = occupied &&
                   ((entry_reg.run_at > new_entry.run_at) ||
                    ((entry_reg.run_at == new_entry.run_at) &&
                     (entry_reg.prio > new_entry.prio)));

    assign match = occupied && (entry_reg.job_id == new_entry.job_id);

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.push)
        begin
            if (prev_after)
            begin
                entry_next = prev_entry;
            end
            else if (after || !occupied)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.remove && shift_up)
        begin
            entry_next = next_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ design/jdpq_scan.sv @@
// ----------------------------------------------------------------------------
// jdpq_scan: prefix OR over the slot match flags
// Log-depth scan; bit i is set when any slot at or below i matches.
// ----------------------------------------------------------------------------
module jdpq_scan #(
    parameter int WIDTH = 64
) (
    input  logic [WIDTH-1:0] flags,
    output logic [WIDTH-1:0] prefix
);

    localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] stage [LEVELS+1];

    assign stage[0] = flags;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        assign stage[l+1] = stage[l] | (stage[l] << (2 ** l));
    end

    assign prefix = stage[LEVELS];

endmodule

@@ design/job_deadline_priority_queue.sv @@
// ----------------------------------------------------------------------------
// job_deadline_priority_queue: bounded queue of jobs in deadline order
// Sorted row of slot cells with a registered result stage.
// ----------------------------------------------------------------------------
// The queue keeps up to QUEUE_DEPTH jobs in a row of cells, always sorted in
// service order: earliest run time first, then lowest priority value, then
// the job pushed first. Every accepted item is applied in the cycle it is
// taken, so the block takes one item per clock whenever the result register
// is free or being drained; each item yields exactly one result in the
// cycle after. The rate is set by the update of the whole cell row: a push
// compares the new key against every cell at once and each cell either holds,
// takes the new job or takes its upper neighbor; a pop or remove makes the
// cells at and past the affected slot take their lower neighbor. A push to a
// full queue is dropped with status full; a pop of an empty queue reports
// empty; a remove takes out the matching job nearest the head or reports not
// found. entry_count is the job count after the item, cut to seven bits.
// job_stall rises only while a result waits and result_stall is high.
module job_deadline_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_stall,
    input  jdpq_pkg::job_item_t    job,
    output logic                   result_valid,
    input  logic                   result_stall,
    output jdpq_pkg::result_item_t result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    jdpq_pkg::result_item_t result_reg;
    jdpq_pkg::result_item_t result_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 found;
    jdpq_pkg::op_t        op;
    jdpq_pkg::cell_ctrl_t ctrl;
    jdpq_pkg::entry_t     new_entry;

    jdpq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occ_vec;
    logic [QUEUE_DEPTH-1:0] after_vec;
    logic [QUEUE_DEPTH-1:0] match_vec;
    logic [QUEUE_DEPTH-1:0] shift_vec;

    // Take a new item unless a finished result is still held back
    assign job_stall = result_valid_reg && result_stall;
    assign accept    = job_valid && !job_stall;

    assign op    = jdpq_pkg::op_t'(job.operation);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign found = |match_vec;

    assign new_entry.job_id = job.job_id;
    assign new_entry.run_at = job.run_at;
    assign new_entry.prio   = job.priority_req;

    // Drive cell strobes only for operations that change the row
    always_comb
    begin
        ctrl = '0;
        if (accept)
        begin
            unique case (op)
                jdpq_pkg::OP_PUSH:   ctrl.push   = !full;
                jdpq_pkg::OP_POP:    ctrl.pop    = !empty;
                jdpq_pkg::OP_REMOVE: ctrl.remove = found;
                default:             ctrl       = '0;
            endcase
        end
    end

    // Cells at or past the first id match advance one slot toward the head
    jdpq_scan #(
        .WIDTH (QUEUE_DEPTH)
    ) u_scan (
        .flags  (match_vec),
        .prefix (shift_vec)
    );

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        jdpq_pkg::entry_t prev_entry;
        jdpq_pkg::entry_t next_entry;
        logic             prev_after;

        assign occ_vec[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign prev_entry = new_entry;
            assign prev_after = 1'b0;
        end
        else
        begin : g_body
            assign prev_entry = cell_entry[i-1];
            assign prev_after = after_vec[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign next_entry = cell_entry[i+1];
        end

        jdpq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_entry),
            .next_entry (next_entry),
            .occupied   (occ_vec[i]),
            .prev_after (prev_after),
            .shift_up   (shift_vec[i]),
            .entry      (cell_entry[i]),
            .after      (after_vec[i]),
            .match      (match_vec[i])
        );
    end

    // Build the result and the new count for the accepted item
    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (accept)
        begin
            result_next        = '0;
            result_next.status = jdpq_pkg::ST_OK;
            result_valid_next  = 1'b1;
            unique case (op)
                jdpq_pkg::OP_PUSH:
                begin
                    if (full)
                    begin
                        result_next.status = jdpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                jdpq_pkg::OP_POP:
                begin
                    if (empty)
                    begin
                        result_next.status = jdpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        result_next.out_job_id   = cell_entry[0].job_id;
                        result_next.out_run_at   = cell_entry[0].run_at;
                        result_next.out_priority = cell_entry[0].prio;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                jdpq_pkg::OP_REMOVE:
                begin
                    if (found)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        result_next.status = jdpq_pkg::ST_NOT_FOUND;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
            result_next.entry_count = jdpq_pkg::COUNT_BITS'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
